FILE: src/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants for the PNG scanline unfilter
// Widths, register indexes, filter-type codes and the Paeth predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    localparam int MAX_LINE_BYTES  = 4096;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 4;
    localparam int LINE_W     = 13;
    localparam int ROWS_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_USER_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Paeth predictor: pick the neighbor closest to a + b - c
    function automatic logic [BYTE_W-1:0] paeth_pred(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+1:0] pa;
        logic signed [BYTE_W+1:0] pb;
        logic signed [BYTE_W+1:0] pc;
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG filter reconstruction (None/Sub/Up/Average/Paeth)
// Byte-wide stream in, reconstructed bytes out, prior row kept in a line store.
// ----------------------------------------------------------------------------
// The accept edge loads the decode/line-store read stage; when that stage fires,
// the result register is loaded and the word is then on m_tdata.
// Throughput: one word per cycle sustained unless m_tready stalls the output; the line
// store is read at the decode stage, written when the word leaves the reconstruct stage.
// Reset (aresetn low, synchronous) clears control state and sets the configuration
// registers to 1; the line store is not cleared and holds garbage until first written.
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // slave side
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [psu_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] stream_byte
    input  wire                                s_tuser,   // [0] start_image
    // master side
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [psu_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] pixel_byte
    output logic                               m_tlast,   // end_of_line
    output logic [psu_pkg::OUT_USER_W-1:0]     m_tuser,   // [0] end_of_image, [1] bad_filter
    // configuration
    input  wire                                cfg_we,
    input  wire  [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [psu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int POS_W = $clog2(MAX_LINE_BYTES);
    localparam int LCW   = (POS_W + 1 > psu_pkg::LINE_W) ? POS_W + 1 : psu_pkg::LINE_W;
    localparam int HIW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int RCW   = psu_pkg::ROWS_W + 1;
    localparam int BW    = psu_pkg::BYTE_W;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_FILT,
        KIND_BAD,
        KIND_DATA
    } kind_t;

    // configuration registers
    logic [psu_pkg::BPP_W-1:0]  cfg_bpp_reg;
    logic [psu_pkg::LINE_W-1:0] cfg_line_reg;
    logic [psu_pkg::ROWS_W-1:0] cfg_rows_reg;

    // row control state
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [psu_pkg::ROWS_W-1:0] row_reg, row_next;
    psu_pkg::filt_t             filt_reg, filt_next;
    logic                       expect_reg, expect_next;
    logic                       first_reg, first_next;
    logic                       err_reg, err_next;

    // decode stage
    logic                       s1_valid_reg;
    kind_t                      s1_kind_reg, s1_kind_next;
    logic [BW-1:0]              s1_byte_reg;
    psu_pkg::filt_t             s1_filt_reg;
    logic [POS_W-1:0]           s1_pos_reg;
    logic                       s1_first_reg;
    logic                       s1_aok_reg, s1_aok_next;
    logic [HIW-1:0]             s1_bidx_reg, s1_bidx_next;
    logic                       s1_eol_reg, s1_eol_next;
    logic                       s1_eoi_reg, s1_eoi_next;

    // line store and neighbor histories
    logic [BW-1:0]              line_mem [MAX_LINE_BYTES];
    logic [BW-1:0]              rd_reg;
    logic [BW-1:0]              left_reg  [MAX_PIXEL_BYTES];
    logic [BW-1:0]              above_reg [MAX_PIXEL_BYTES];

    // result register
    logic                       m_valid_reg;
    logic [BW-1:0]              m_byte_reg;
    logic                       m_last_reg;
    logic                       m_eoi_reg;
    logic                       m_bad_reg;

    logic                       in_fire;
    logic                       s1_fire;
    logic                       s1_has_result;

    logic [psu_pkg::BPP_W-1:0]  bpp_eff;
    logic [LCW-1:0]             line_ext, line_max, line_eff, pos_inc;
    logic [RCW-1:0]             rows_eff, row_inc;
    logic                       st_err, st_expect, st_first;
    logic [POS_W-1:0]           st_pos;
    logic [psu_pkg::ROWS_W-1:0] st_row;

    logic [BW-1:0]              nb_a, nb_b, nb_c, pred, val;
    logic [BW:0]                avg_sum;

    // ---------------------------------------------------------------- handshake
    assign s1_has_result = (s1_kind_reg == KIND_DATA) || (s1_kind_reg == KIND_BAD);
    assign s1_fire  = s1_valid_reg && (!s1_has_result || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // ---------------------------------------------------------------- decode
    always_comb begin
        if (cfg_bpp_reg == '0) begin
            bpp_eff = psu_pkg::BPP_W'(1);
        end else if (cfg_bpp_reg > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = cfg_bpp_reg;
        end

        line_ext = LCW'(cfg_line_reg);
        line_max = LCW'(MAX_LINE_BYTES);
        if (line_ext == '0) begin
            line_eff = LCW'(1);
        end else if (line_ext > line_max) begin
            line_eff = line_max;
        end else begin
            line_eff = line_ext;
        end
        rows_eff = (cfg_rows_reg == '0) ? RCW'(1) : RCW'(cfg_rows_reg);

        // start of image overrides the row state for this word
        st_err    = s_tuser ? 1'b0 : err_reg;
        st_expect = s_tuser ? 1'b1 : expect_reg;
        st_first  = s_tuser ? 1'b1 : first_reg;
        st_pos    = s_tuser ? '0   : pos_reg;
        st_row    = s_tuser ? '0   : row_reg;

        pos_inc  = LCW'(st_pos) + LCW'(1);
        row_inc  = RCW'(st_row) + RCW'(1);

        err_next     = st_err;
        expect_next  = st_expect;
        first_next   = st_first;
        pos_next     = st_pos;
        row_next     = st_row;
        filt_next    = filt_reg;
        s1_kind_next = KIND_DROP;
        s1_eol_next  = 1'b0;
        s1_eoi_next  = 1'b0;
        s1_bidx_next = HIW'(bpp_eff - psu_pkg::BPP_W'(1));
        s1_aok_next  = LCW'(st_pos) >= LCW'(bpp_eff);

        if (st_err) begin
            s1_kind_next = KIND_DROP;
        end else if (st_expect) begin
            if (s_tdata > BW'(psu_pkg::FILT_PAETH)) begin
                s1_kind_next = KIND_BAD;
                err_next     = 1'b1;
            end else begin
                s1_kind_next = KIND_FILT;
                filt_next    = psu_pkg::filt_t'(s_tdata[2:0]);
                expect_next  = 1'b0;
                pos_next     = '0;
            end
        end else begin
            s1_kind_next = KIND_DATA;
            if (pos_inc >= line_eff) begin
                s1_eol_next = 1'b1;
                expect_next = 1'b1;
                pos_next    = '0;
                if (row_inc >= rows_eff) begin
                    s1_eoi_next = 1'b1;
                    row_next    = '0;
                    first_next  = 1'b1;
                end else begin
                    row_next    = row_inc[psu_pkg::ROWS_W-1:0];
                    first_next  = 1'b0;
                end
            end else begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- reconstruct
    always_comb begin
        nb_a    = s1_aok_reg ? left_reg[s1_bidx_reg] : '0;
        nb_b    = s1_first_reg ? '0 : rd_reg;
        nb_c    = (s1_first_reg || !s1_aok_reg) ? '0 : above_reg[s1_bidx_reg];
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (s1_filt_reg)
            psu_pkg::FILT_NONE:  pred = '0;
            psu_pkg::FILT_SUB:   pred = nb_a;
            psu_pkg::FILT_UP:    pred = nb_b;
            psu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
            psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pred(nb_a, nb_b, nb_c);
            default:             pred = '0;
        endcase
        val = s1_byte_reg + pred;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_bpp_reg  <= psu_pkg::BPP_W'(1);
            cfg_line_reg <= psu_pkg::LINE_W'(1);
            cfg_rows_reg <= psu_pkg::ROWS_W'(1);
            pos_reg      <= '0;
            row_reg      <= '0;
            filt_reg     <= psu_pkg::FILT_NONE;
            expect_reg   <= 1'b1;
            first_reg    <= 1'b1;
            err_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_DROP;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    psu_pkg::CFG_BPP:  cfg_bpp_reg  <= cfg_wdata[psu_pkg::BPP_W-1:0];
                    psu_pkg::CFG_LINE: cfg_line_reg <= cfg_wdata[psu_pkg::LINE_W-1:0];
                    psu_pkg::CFG_ROWS: cfg_rows_reg <= cfg_wdata[psu_pkg::ROWS_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                pos_reg      <= pos_next;
                row_reg      <= row_next;
                filt_reg     <= filt_next;
                expect_reg   <= expect_next;
                first_reg    <= first_next;
                err_reg      <= err_next;
                s1_valid_reg <= 1'b1;
                s1_kind_reg  <= s1_kind_next;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && s1_has_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the decode stage; line store read one word ahead
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_byte_reg  <= s_tdata;
            s1_filt_reg  <= filt_reg;
            s1_pos_reg   <= st_pos;
            s1_first_reg <= st_first;
            s1_aok_reg   <= s1_aok_next;
            s1_bidx_reg  <= s1_bidx_next;
            s1_eol_reg   <= s1_eol_next;
            s1_eoi_reg   <= s1_eoi_next;
            rd_reg       <= line_mem[st_pos];
        end
        if (s1_fire && s1_kind_reg == KIND_DATA) begin
            line_mem[s1_pos_reg] <= val;
        end
    end

    // neighbor histories, newest first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                left_reg[k]  <= '0;
                above_reg[k] <= '0;
            end
        end else if (s1_fire) begin
            if (s1_kind_reg == KIND_DATA) begin
                left_reg[0]  <= val;
                above_reg[0] <= nb_b;
                for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                    left_reg[k]  <= left_reg[k-1];
                    above_reg[k] <= above_reg[k-1];
                end
            end else if (s1_kind_reg == KIND_FILT || s1_kind_reg == KIND_BAD) begin
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    left_reg[k]  <= '0;
                    above_reg[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_has_result) begin
            if (s1_kind_reg == KIND_BAD) begin
                m_byte_reg <= '0;
                m_last_reg <= 1'b0;
                m_eoi_reg  <= 1'b0;
                m_bad_reg  <= 1'b1;
            end else begin
                m_byte_reg <= val;
                m_last_reg <= s1_eol_reg;
                m_eoi_reg  <= s1_eoi_reg;
                m_bad_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_bad_reg, m_eoi_reg};

endmodule

`default_nettype wire

FILE: src/psu_checker.sv
// ----------------------------------------------------------------------------
// psu_checker: port-level checks for the PNG scanline unfilter
// Watches the master side and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [psu_pkg::BYTE_W-1:0]          m_tdata,
    input wire                                m_tlast,
    input wire [psu_pkg::OUT_USER_W-1:0]      m_tuser
);

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled output word changed");

    // a bad-filter word carries nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tlast && !m_tuser[0])
        else $error("bad_filter word with payload");

    // the last byte of an image is also the last byte of its line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("end_of_image without end_of_line");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
